// ===== sv/qor_pkg.sv =====
// shared types, constants and helper functions of the quaternion rotator
`default_nettype none
package qor_pkg;

	localparam int HW = 38;
	localparam int CORDIC_STEPS = 30;

	localparam logic signed [HW-1:0] PI_Q30      = 38'sd3373259426;
	localparam logic signed [HW-1:0] TWO_PI_Q30  = 38'sd6746518852;
	localparam logic signed [HW-1:0] HALF_PI_Q30 = 38'sd1686629713;
	localparam logic signed [33:0]   CORDIC_GAIN = 34'sd652032874;
	localparam logic [29:0]          TOL_RESET   = 30'd1074;
	localparam logic [63:0]          ONE_Q30     = 64'd1073741824;

	typedef enum logic {
		ACT_ROTATE = 1'b0,
		ACT_SET    = 1'b1
	} act_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic signed [31:0] angle;
	} item_t;

	typedef struct packed {
		logic signed [31:0] orient_x;
		logic signed [31:0] orient_y;
		logic signed [31:0] orient_z;
		logic signed [31:0] orient_w;
	} result_t;

	// classified command handed from the front to the engine
	typedef struct packed {
		act_t               action;
		logic               flip;
		logic signed [HW-1:0] half;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_Q2,
		ST_COPY,
		ST_PROD,
		ST_MAG,
		ST_CHECK,
		ST_SQRT,
		ST_DIVINIT,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} st_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543516;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			5'd24: r = 30'd64;
			5'd25: r = 30'd32;
			5'd26: r = 30'd16;
			5'd27: r = 30'd8;
			5'd28: r = 30'd4;
			5'd29: r = 30'd2;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// sign of one Hamilton product term: component c, stored index t
	function automatic logic hamilton_neg(input logic [1:0] c, input logic [1:0] t);
		logic r;
		unique case ({c, t})
			4'b0010, 4'b0100, 4'b1001, 4'b1100, 4'b1101, 4'b1110: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/quaternion_orientation_rotator_core.sv =====
// top level of the quaternion orientation rotator
// usage:
//  - input words enter through push/full; each carries action, axis and angle
//    (set loads the orientation from axis-angle, rotate multiplies it in)
//  - results leave through empty/pop; the oldest word sits on result while
//    empty is low, one result word per input word, in order
//  - cfg_valid/cfg_ready writes norm_tolerance; cfg_ready is always high;
//    write it only while no word is in flight
//  - the front reduces the half angle and queues two commands, so input is
//    taken while the engine works; a two-word result queue decouples pop
//  - the shared engine runs 30 cordic steps, then the multiplies, and when
//    renormalization runs 32 square root steps and 62 divide steps for
//    four lanes at once
//  - one word at a time in the engine: it pops the next command only
//    after pushing the result of the last one
//  - reset clears the queues, loads the identity orientation and the
//    tolerance reset value
//  - when pop stays low the result queue fills, the engine holds its word,
//    then the command queue fills and full rises
`default_nettype none
module quaternion_orientation_rotator_core #(
	parameter int FRAC_BITS = 30
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire qor_pkg::item_t   item,
	output logic                  full,
	output logic                  empty,
	input  wire logic             pop,
	output qor_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [29:0]      cfg_data
);

	// tolerance register
	logic [29:0] tol_q;

	// front to engine command queue
	logic          cmd_pop;
	logic          cmd_empty;
	qor_pkg::cmd_t cmd;

	// engine to result queue
	logic             res_push;
	logic             res_full;
	qor_pkg::result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= qor_pkg::TOL_RESET;
		else if (cfg_valid && cfg_ready)
			tol_q <= cfg_data;
	end

	qor_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd       (cmd)
	);

	qor_engine #(
		.FRAC_BITS (FRAC_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.tol       (tol_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue lets the engine finish while the reader stalls
	qor_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

endmodule
`default_nettype wire

// ===== sv/qor_front.sv =====
// input side: takes words, reduces the half angle and queues commands
`default_nettype none
module qor_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire qor_pkg::item_t item,
	output logic                full,
	input  wire logic           cmd_pop,
	output logic                cmd_empty,
	output qor_pkg::cmd_t       cmd
);

	logic signed [qor_pkg::HW-1:0] h0, h1, h2;
	logic                          flip;
	qor_pkg::cmd_t                 cmd_in;
	qor_pkg::cmd_t                 mem_q [2];
	logic                          wr_q, rd_q;
	logic [1:0]                    cnt_q;
	logic                          do_push;

	// 4*angle read as Q.30 radians, one wrap by 2*pi, then fold into half circle
	always_comb begin
		h0 = {{4{item.angle[31]}}, item.angle, 2'b00};
		if (h0 > qor_pkg::PI_Q30)
			h1 = h0 - qor_pkg::TWO_PI_Q30;
		else if (h0 < -qor_pkg::PI_Q30)
			h1 = h0 + qor_pkg::TWO_PI_Q30;
		else
			h1 = h0;
		flip = 1'b0;
		h2 = h1;
		if (h1 > qor_pkg::HALF_PI_Q30) begin
			h2 = qor_pkg::PI_Q30 - h1;
			flip = 1'b1;
		end else if (h1 < -qor_pkg::HALF_PI_Q30) begin
			h2 = -qor_pkg::PI_Q30 - h1;
			flip = 1'b1;
		end
		cmd_in.action = item.action ? qor_pkg::ACT_SET : qor_pkg::ACT_ROTATE;
		cmd_in.flip   = flip;
		cmd_in.half   = h2;
		cmd_in.ax     = item.axis_x;
		cmd_in.ay     = item.axis_y;
		cmd_in.az     = item.axis_z;
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_empty = cnt_q == 2'd0;
	assign do_push   = push && !full;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (cmd_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(cmd_pop);
		end
	end

endmodule
`default_nettype wire

// ===== sv/qor_res_queue.sv =====
// two-entry result queue in front of the result ports
`default_nettype none
module qor_res_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire qor_pkg::result_t din,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output qor_pkg::result_t      dout
);

	qor_pkg::result_t mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ===== sv/qor_engine.sv =====
// back end: cordic, quaternion product, magnitude, square root and divide
`default_nettype none
module qor_engine #(
	parameter int FRAC_BITS = 30
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_empty,
	input  wire qor_pkg::cmd_t cmd,
	output logic               cmd_pop,
	input  wire logic [29:0]   tol,
	input  wire logic          res_full,
	output logic               res_push,
	output qor_pkg::result_t   res
);

	localparam int CSH = 30 - FRAC_BITS;
	localparam int MSH = 2 * FRAC_BITS - 32;
	localparam int PSH = FRAC_BITS - 2;
	localparam int NSH = FRAC_BITS - 1;
	localparam logic signed [33:0] CRND = (34'sd1 <<< CSH) >>> 1;
	localparam logic signed [63:0] PRND = 64'sd1 <<< (PSH - 1);
	localparam logic signed [63:0] QRND = 64'sd1 <<< 29;

	qor_pkg::st_t st_q, st_d;
	qor_pkg::cmd_t cmd_q;
	logic [5:0]  cnt_q;
	logic        ph_q;
	logic signed [33:0] x_q, y_q;
	logic signed [qor_pkg::HW-1:0] h_q;
	logic signed [31:0] q2_q [4];
	logic signed [31:0] quat_q [4];
	logic signed [31:0] qn_q [4];
	logic signed [63:0] prod_q, acc_q;
	logic [63:0] m_q, n_q, root_q, bit_q;
	logic [31:0] dvs_q;
	logic [61:0] num_q [4];
	logic [61:0] quo_q [4];
	logic [31:0] rem_q [4];

	logic [1:0]  cc, tt;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [33:0] xs, ys, cval;
	logic signed [31:0] qcur;
	logic [31:0] mcur;
	logic signed [63:0] term, acc_n;
	logic [63:0] m30, diff, sq_t;

	assign cc = cnt_q[3:2];
	assign tt = cnt_q[1:0];
	assign qcur = qn_q[tt];
	assign mcur = qcur[31] ? 32'(-qcur) : 32'(qcur);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			qor_pkg::ST_Q2: begin
				case (tt)
					2'd0:    mul_a = 33'(cmd_q.ax);
					2'd1:    mul_a = 33'(cmd_q.ay);
					default: mul_a = 33'(cmd_q.az);
				endcase
				mul_b = 33'(y_q);
			end
			qor_pkg::ST_PROD: begin
				mul_a = 33'(quat_q[tt]);
				mul_b = 33'(q2_q[tt ^ ~cc]);
			end
			qor_pkg::ST_MAG: begin
				mul_a = {1'b0, mcur};
				mul_b = {1'b0, mcur};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		xs   = x_q >>> cnt_q[4:0];
		ys   = y_q >>> cnt_q[4:0];
		cval = cmd_q.flip ? -x_q : x_q;
		term = prod_q >>> 2;
		acc_n = qor_pkg::hamilton_neg(cc, tt) ? acc_q - term : acc_q + term;
		m30  = m_q >> MSH;
		diff = (m30 > qor_pkg::ONE_Q30) ? m30 - qor_pkg::ONE_Q30 : qor_pkg::ONE_Q30 - m30;
		sq_t = root_q + bit_q;
	end

	// next state and handshakes
	always_comb begin
		st_d     = st_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		unique case (st_q)
			qor_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					st_d = qor_pkg::ST_CORDIC;
				end
			end
			qor_pkg::ST_CORDIC: begin
				if (cnt_q == 6'(qor_pkg::CORDIC_STEPS - 1))
					st_d = qor_pkg::ST_Q2;
			end
			qor_pkg::ST_Q2: begin
				if (ph_q && tt == 2'd2)
					st_d = (cmd_q.action == qor_pkg::ACT_SET) ? qor_pkg::ST_COPY
						: qor_pkg::ST_PROD;
			end
			qor_pkg::ST_COPY: st_d = qor_pkg::ST_MAG;
			qor_pkg::ST_PROD: begin
				if (ph_q && cnt_q[3:0] == 4'hf)
					st_d = qor_pkg::ST_MAG;
			end
			qor_pkg::ST_MAG: begin
				if (ph_q && tt == 2'd3)
					st_d = qor_pkg::ST_CHECK;
			end
			qor_pkg::ST_CHECK: begin
				st_d = (diff < 64'(tol)) ? qor_pkg::ST_DONE : qor_pkg::ST_SQRT;
			end
			qor_pkg::ST_SQRT: begin
				if (cnt_q == 6'd31)
					st_d = qor_pkg::ST_DIVINIT;
			end
			qor_pkg::ST_DIVINIT: begin
				st_d = (root_q == 64'd0) ? qor_pkg::ST_DONE : qor_pkg::ST_DIV;
			end
			qor_pkg::ST_DIV: begin
				if (cnt_q == 6'd61)
					st_d = qor_pkg::ST_FIX;
			end
			qor_pkg::ST_FIX: st_d = qor_pkg::ST_DONE;
			qor_pkg::ST_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					st_d = qor_pkg::ST_IDLE;
				end
			end
			default: st_d = qor_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= qor_pkg::ST_IDLE;
		else
			st_q <= st_d;
	end

	// stored orientation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0] <= '0;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= 32'sd1 <<< FRAC_BITS;
		end else if (res_push) begin
			for (int l = 0; l < 4; l++)
				quat_q[l] <= qn_q[l];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic [32:0] rsh;
		logic        ge;
		prod_q <= mul_p[63:0];
		case (st_q)
			qor_pkg::ST_IDLE: begin
				cmd_q <= cmd;
				x_q   <= qor_pkg::CORDIC_GAIN;
				y_q   <= '0;
				h_q   <= cmd.half;
				cnt_q <= '0;
			end
			qor_pkg::ST_CORDIC: begin
				if (!h_q[qor_pkg::HW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					h_q <= h_q - qor_pkg::HW'(qor_pkg::atan_q30(cnt_q[4:0]));
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					h_q <= h_q + qor_pkg::HW'(qor_pkg::atan_q30(cnt_q[4:0]));
				end
				cnt_q <= (cnt_q == 6'(qor_pkg::CORDIC_STEPS - 1)) ? 6'd0 : cnt_q + 6'd1;
				ph_q  <= 1'b0;
			end
			qor_pkg::ST_Q2: begin
				if (!ph_q) begin
					if (tt == 2'd0)
						q2_q[3] <= qor_pkg::sat32(66'((cval + CRND) >>> CSH));
				end else begin
					q2_q[tt] <= qor_pkg::sat32(66'((prod_q + QRND) >>> 30));
					cnt_q <= (tt == 2'd2) ? 6'd0 : cnt_q + 6'd1;
				end
				ph_q  <= !ph_q;
				acc_q <= '0;
				m_q   <= '0;
			end
			qor_pkg::ST_COPY: begin
				for (int l = 0; l < 4; l++)
					qn_q[l] <= q2_q[l];
				cnt_q <= '0;
				ph_q  <= 1'b0;
			end
			qor_pkg::ST_PROD: begin
				if (ph_q) begin
					if (tt == 2'd3) begin
						qn_q[cc] <= qor_pkg::sat32(66'((acc_n + PRND) >>> PSH));
						acc_q <= '0;
					end else begin
						acc_q <= acc_n;
					end
					cnt_q <= (cnt_q[3:0] == 4'hf) ? 6'd0 : cnt_q + 6'd1;
				end
				ph_q <= !ph_q;
			end
			qor_pkg::ST_MAG: begin
				if (ph_q) begin
					m_q   <= m_q + {2'b00, prod_q[63:2]};
					cnt_q <= (tt == 2'd3) ? 6'd0 : cnt_q + 6'd1;
				end
				ph_q <= !ph_q;
			end
			qor_pkg::ST_CHECK: begin
				n_q    <= m_q;
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
				cnt_q  <= '0;
			end
			qor_pkg::ST_SQRT: begin
				if (n_q >= sq_t) begin
					n_q    <= n_q - sq_t;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= (cnt_q == 6'd31) ? 6'd0 : cnt_q + 6'd1;
			end
			qor_pkg::ST_DIVINIT: begin
				dvs_q <= root_q[31:0];
				for (int l = 0; l < 4; l++) begin
					num_q[l] <= (62'($unsigned(qn_q[l][31] ? -qn_q[l] : qn_q[l])) << NSH)
						+ 62'(root_q[31:1]);
					rem_q[l] <= '0;
					quo_q[l] <= '0;
				end
				cnt_q <= '0;
			end
			qor_pkg::ST_DIV: begin
				for (int l = 0; l < 4; l++) begin
					rsh = {rem_q[l], num_q[l][61]};
					ge  = rsh >= {1'b0, dvs_q};
					rem_q[l] <= ge ? 32'(rsh - {1'b0, dvs_q}) : rsh[31:0];
					num_q[l] <= num_q[l] << 1;
					quo_q[l] <= {quo_q[l][60:0], ge};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			qor_pkg::ST_FIX: begin
				for (int l = 0; l < 4; l++) begin
					if (qn_q[l][31])
						qn_q[l] <= (quo_q[l] >= 62'd2147483648) ? 32'sh80000000
							: -$signed(quo_q[l][31:0]);
					else
						qn_q[l] <= (quo_q[l] > 62'd2147483647) ? 32'sh7fffffff
							: $signed(quo_q[l][31:0]);
				end
			end
			default: begin
				ph_q <= 1'b0;
			end
		endcase
	end

	assign res.orient_x = qn_q[0];
	assign res.orient_y = qn_q[1];
	assign res.orient_z = qn_q[2];
	assign res.orient_w = qn_q[3];

`ifndef SYNTHESIS
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> st_q == qor_pkg::ST_CORDIC)
		else $error("command pop did not start cordic");
	a_push_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> st_q == qor_pkg::ST_IDLE)
		else $error("result push did not return to idle");
	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == qor_pkg::ST_CORDIC |-> cnt_q < 6'(qor_pkg::CORDIC_STEPS))
		else $error("cordic step count out of range");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench of the quaternion orientation rotator: table of directed words, then random words
`timescale 1ns / 100ps
`default_nettype none
module tb;

	localparam int FB = 30;
	localparam int IDLE_GAP = 400;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	qor_pkg::item_t item = '0;
	logic full, empty;
	logic pop = 1'b0;
	qor_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [29:0] cfg_data = '0;

	quaternion_orientation_rotator_core #(.FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state: orientation and tolerance
	longint orient_q[4];
	longint tolerance;
	qor_pkg::result_t orient_pending[$];
	int unsigned mismatches = 0;
	int unsigned words_in = 0, words_out = 0, set_words = 0, rotate_words = 0;
	int unsigned push_idle_pct = 0, pop_idle_pct = 0;
	int unsigned quiet_cycles = 0;

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		if (s == 0) return v;
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint atan_step(int i);
		longint steps[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
			131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
			32, 16, 8, 4, 2};
		return steps[i];
	endfunction

	// half-angle sine and cosine by rotation-mode cordic
	function automatic void half_sincos(input longint h, output longint s,
			output longint c);
		longint pi_v, x, y, t;
		bit folded;
		pi_v = 64'sd3373259426;
		folded = 1'b0;
		x = 64'sd652032874;
		y = 0;
		if (h > pi_v) h -= 64'sd6746518852;
		else if (h < -pi_v) h += 64'sd6746518852;
		if (h > 64'sd1686629713) begin
			h = pi_v - h;
			folded = 1'b1;
		end else if (h < -64'sd1686629713) begin
			h = -pi_v - h;
			folded = 1'b1;
		end
		for (int i = 0; i < 30; i++) begin
			if (h >= 0) begin
				t = x - asr64(y, i);
				y = y + asr64(x, i);
				h -= atan_step(i);
			end else begin
				t = x + asr64(y, i);
				y = y - asr64(x, i);
				h += atan_step(i);
			end
			x = t;
		end
		s = y;
		c = folded ? -x : x;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// renormalize unless the squared magnitude is within tolerance of one
	function automatic void renormalize(inout longint q[4]);
		longint unsigned m, a, m30, diff, root, r;
		m = 0;
		for (int i = 0; i < 4; i++) begin
			a = q[i] < 0 ? longint'(-q[i]) : q[i];
			m += (a * a) >> 2;
		end
		m30 = m >> (2 * FB - 32);
		diff = m30 > 64'd1073741824 ? m30 - 64'd1073741824 : 64'd1073741824 - m30;
		if (diff < longint'(tolerance)) return;
		root = int_sqrt(m);
		if (root == 0) return;
		for (int i = 0; i < 4; i++) begin
			a = (q[i] < 0 ? longint'(-q[i]) : q[i]) << (FB - 1);
			r = (a + (root >> 1)) / root;
			q[i] = clamp32(q[i] < 0 ? -longint'(r) : longint'(r));
		end
	endfunction

	// advance the orientation by one word and return the new quaternion
	function automatic qor_pkg::result_t next_orientation(qor_pkg::item_t w);
		longint s, c, v2[4], p[4], q[4];
		qor_pkg::result_t r;
		half_sincos(longint'(w.angle) * 4, s, c);
		v2[0] = clamp32(round_shift(longint'(w.axis_x) * s, 30));
		v2[1] = clamp32(round_shift(longint'(w.axis_y) * s, 30));
		v2[2] = clamp32(round_shift(longint'(w.axis_z) * s, 30));
		v2[3] = clamp32(round_shift(c, 30 - FB));
		if (qor_pkg::act_t'(w.action) == qor_pkg::ACT_SET) begin
			q = v2;
		end else begin
			p = orient_q;
			q[0] = asr64(p[3]*v2[0],2) + asr64(p[0]*v2[3],2) + asr64(p[1]*v2[2],2)
				- asr64(p[2]*v2[1],2);
			q[1] = asr64(p[3]*v2[1],2) - asr64(p[0]*v2[2],2) + asr64(p[1]*v2[3],2)
				+ asr64(p[2]*v2[0],2);
			q[2] = asr64(p[3]*v2[2],2) + asr64(p[0]*v2[1],2) - asr64(p[1]*v2[0],2)
				+ asr64(p[2]*v2[3],2);
			q[3] = asr64(p[3]*v2[3],2) - asr64(p[0]*v2[0],2) - asr64(p[1]*v2[1],2)
				- asr64(p[2]*v2[2],2);
			for (int i = 0; i < 4; i++) q[i] = clamp32(round_shift(q[i], FB - 2));
		end
		renormalize(q);
		orient_q = q;
		r.orient_x = q[0][31:0];
		r.orient_y = q[1][31:0];
		r.orient_z = q[2][31:0];
		r.orient_w = q[3][31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s at %0t: got %h, want %h", what, $realtime, got, want);
		mismatches++;
	endtask

	// result side: pop at random, compare at the rising edge
	always @(posedge clk) begin
		qor_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			words_out++;
			if (orient_pending.size() == 0) begin
				report_mismatch("unexpected word", result.orient_x, '0);
			end else begin
				want = orient_pending.pop_front();
				if (result.orient_x !== want.orient_x)
					report_mismatch("orient_x", result.orient_x, want.orient_x);
				if (result.orient_y !== want.orient_y)
					report_mismatch("orient_y", result.orient_y, want.orient_y);
				if (result.orient_z !== want.orient_z)
					report_mismatch("orient_z", result.orient_z, want.orient_z);
				if (result.orient_w !== want.orient_w)
					report_mismatch("orient_w", result.orient_w, want.orient_w);
			end
		end
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= pop_idle_pct);
	end

	// watchdog: cycles in which nothing moves
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("[quaternion_orientation_rotator_core] ERROR");
			$finish;
		end
	end

	// send one word; the expectation is formed when it is accepted
	task automatic send_word(input qor_pkg::item_t w);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		orient_pending.push_back(next_orientation(w));
		words_in++;
		if (qor_pkg::act_t'(w.action) == qor_pkg::ACT_SET) set_words++;
		else rotate_words++;
		@(negedge clk);
	endtask

	// wait for every result, then let the engine settle before a write
	task automatic drain;
		push <= 1'b0;
		while (orient_pending.size() != 0) @(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	task automatic write_tolerance(input logic [29:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tolerance = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic qor_pkg::item_t make_word(qor_pkg::act_t a, int ax, int ay,
			int az, int ang);
		qor_pkg::item_t w;
		w.action = a;
		w.axis_x = ax;
		w.axis_y = ay;
		w.axis_z = az;
		w.angle = ang;
		return w;
	endfunction

	// random word: mostly unit axes and moderate angles, some raw noise
	function automatic qor_pkg::item_t random_word();
		qor_pkg::item_t w;
		int unsigned kind;
		kind = $urandom_range(9);
		w.action = ($urandom_range(3) == 0) ? qor_pkg::ACT_SET : qor_pkg::ACT_ROTATE;
		if (kind < 7) begin
			w.axis_x = 0;
			w.axis_y = 0;
			w.axis_z = 0;
			case ($urandom_range(3))
				0: w.axis_x = $urandom_range(1) ? 32'sd1073741824 : -32'sd1073741824;
				1: w.axis_y = $urandom_range(1) ? 32'sd1073741824 : -32'sd1073741824;
				2: w.axis_z = $urandom_range(1) ? 32'sd1073741824 : -32'sd1073741824;
				default: begin
					w.axis_x = $signed($urandom_range(1240000000)) - 620000000;
					w.axis_y = $signed($urandom_range(1240000000)) - 620000000;
					w.axis_z = $signed($urandom_range(1240000000)) - 620000000;
				end
			endcase
			w.angle = $signed($urandom_range(1700000000)) - 850000000;
		end else begin
			w.axis_x = $urandom;
			w.axis_y = $urandom;
			w.axis_z = $urandom;
			w.angle = $urandom;
		end
		return w;
	endfunction

	typedef struct {
		qor_pkg::item_t w;
		bit typed;
		qor_pkg::result_t want;
	} stim_row_t;

	stim_row_t directed_rows[$];

	task automatic add_row(qor_pkg::item_t w, bit typed, qor_pkg::result_t want);
		stim_row_t r;
		r.w = w;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endtask

	initial begin
		qor_pkg::result_t ident, typed_want;
		longint saved_q[4];
		ident = '{orient_x: 0, orient_y: 0, orient_z: 0, orient_w: 32'sd1073741824};
		orient_q = '{0, 0, 0, longint'(1) << FB};
		tolerance = qor_pkg::TOL_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero angle after reset, then unit axes with moderate angles
		add_row(make_word(qor_pkg::ACT_ROTATE, 0, 0, 0, 0), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_SET, 32'sd1073741824, 0, 0, 0), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_SET, 32'sd1073741824, 0, 0, 32'sd421657428),
			1'b0, ident);
		add_row(make_word(qor_pkg::ACT_ROTATE, 0, 32'sd1073741824, 0, 32'sd210828714),
			1'b0, ident);
		add_row(make_word(qor_pkg::ACT_ROTATE, 0, 0, -32'sd1073741824, -32'sd843314857),
			1'b0, ident);
		// extreme fields: saturating axes and angles at both ends
		add_row(make_word(qor_pkg::ACT_SET, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_ROTATE, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_ROTATE, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh40000000), 1'b0, ident);
		// zero axis: zero magnitude never reached, set w only; then mixed bit patterns
		add_row(make_word(qor_pkg::ACT_SET, 0, 0, 0, 32'sd843314857), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_SET, 0, 0, 0, 32'sh7fffffff), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_ROTATE, 32'shffffffff, 32'sh00000001, 0,
			32'sh80000000), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_SET, 32'sh55555555, 32'shaaaaaaaa, 32'sh33333333,
			32'shcccccccc), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_ROTATE, 32'shaaaaaaaa, 32'sh55555555,
			32'shcccccccc, 32'sh33333333), 1'b0, ident);
		add_row(make_word(qor_pkg::ACT_SET, 0, 0, 32'sd1073741824, 32'sd421657428),
			1'b0, ident);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed) begin
				// typed rows check the predictor without advancing its state
				saved_q = orient_q;
				typed_want = next_orientation(directed_rows[i].w);
				orient_q = saved_q;
				if (typed_want !== directed_rows[i].want)
					report_mismatch("predictor vs table", typed_want.orient_w,
						directed_rows[i].want.orient_w);
			end
			send_word(directed_rows[i].w);
		end
		drain();

		// three idling phases, each under its own tolerance
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin push_idle_pct = 27; pop_idle_pct = 72; write_tolerance(30'd0); end
				1: begin push_idle_pct = 72; pop_idle_pct = 27;
					write_tolerance(30'h3fffffff); end
				default: begin push_idle_pct = 0; pop_idle_pct = 0;
					write_tolerance(30'($urandom_range(200000))); end
			endcase
			for (int n = 0; n < 165; n++) send_word(random_word());
			drain();
		end
		write_tolerance(qor_pkg::TOL_RESET);
		for (int n = 0; n < 10; n++) send_word(random_word());
		drain();

		$display("covered %0d words (%0d set, %0d rotate), %0d results checked",
			words_in, set_words, rotate_words, words_out);
		$display("tolerance swept over zero, full scale, random and reset value");
		if (mismatches == 0 && orient_pending.size() == 0) begin
			$display("[quaternion_orientation_rotator_core] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				orient_pending.size());
			$display("[quaternion_orientation_rotator_core] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
